// ----- sv/rouu_pkg.sv -----
package rouu_pkg;

    localparam int MAX_DIM = 64;
    localparam int IDX_W   = $clog2(MAX_DIM);
    localparam int DIM_W   = IDX_W + 1;
    localparam int ADDR_W  = 2 * IDX_W;
    localparam int DATA_W  = 32;
    localparam int CNT_W   = 13;
    localparam int THR_W   = 31;
    localparam int ACC_W   = 56;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [2:0] {
        OP_WRITE    = 3'd0,
        OP_WRITE_U  = 3'd1,
        OP_RATIO    = 3'd2,
        OP_UPDATE   = 3'd3,
        OP_READ     = 3'd4,
        OP_SPARSIFY = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NO_RATIO = 2'd1,
        STAT_ZERO     = 2'd2
    } stat_t;

    localparam logic CFG_MATRIX_SIZE = 1'b0;
    localparam logic CFG_DROP_THR    = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_R_ADDR,
        S_R_MUL,
        S_R_ACC,
        S_R_WR,
        S_R_END,
        S_C_ADDR,
        S_C_WR,
        S_U_ADDR,
        S_U_MUL,
        S_U_DIV,
        S_U_WAIT,
        S_U_WR,
        S_S_ADDR,
        S_S_CHK,
        S_RD_CAP,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        WSEL_DATA,
        WSEL_UPDATE,
        WSEL_ZERO
    } wsel_t;

    typedef enum logic {
        MSEL_RATIO,
        MSEL_UPDATE
    } msel_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic             load;
        logic [IDX_W-1:0] inv_row;
        logic [IDX_W-1:0] inv_col;
        logic [IDX_W-1:0] vec_row;
        logic [IDX_W-1:0] vec_col;
        logic             inv_we;
        wsel_t            inv_wsel;
        logic             u_we;
        logic             w_we;
        logic             orow_we;
        logic             mul_go;
        msel_t            mul_sel;
        logic             acc_add;
        logic             acc_clr;
        logic             ratio_ok;
        logic             ratio_bad;
        logic             valid_clr;
        logic             div_go;
        logic             spar_chk;
        logic             rd_cap;
        logic             out_load;
        stat_t            out_status;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [IDX_W-1:0] moved_row;
        logic             ratio_valid;
        logic             ratio_zero;
        logic             div_done;
        logic             out_free;
    } sts_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [64:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 65'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (v < -65'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

    function automatic logic is_small(input logic signed [DATA_W-1:0] v,
                                      input logic [THR_W-1:0] thr);
        logic signed [DATA_W:0] sv;
        logic [DATA_W:0]        mag;
        sv  = (DATA_W+1)'(v);
        mag = sv[DATA_W] ? $unsigned(-sv) : $unsigned(sv);
        return mag < (DATA_W+1)'(thr);
    endfunction

endpackage

// ----- sv/rouu_ram.sv -----
module rouu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/rouu_div.sv -----
module rouu_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [63:0]  dividend,
    input  logic signed [31:0]  divisor,
    output logic                done,
    output logic signed [63:0]  quotient
);
    import rouu_pkg::*;

    localparam int QW = 63;

    logic              busy_reg;
    logic              done_reg;
    logic [5:0]        cnt_reg;
    logic [QW-1:0]     quo_reg;
    logic [QW-1:0]     quo_next;
    logic [32:0]       rem_reg;
    logic [32:0]       rem_next;
    logic [32:0]       rem_sh;
    logic [31:0]       dvs_reg;
    logic              neg_reg;
    logic signed [63:0] q_reg;
    logic signed [63:0] dvd_mag;
    logic              ge;

    assign dvd_mag = dividend[63] ? -dividend : dividend;

    // One restoring step a cycle
    always_comb
    begin
        rem_sh   = {rem_reg[31:0], quo_reg[QW-1]};
        ge       = rem_sh >= {1'b0, dvs_reg};
        rem_next = ge ? rem_sh - {1'b0, dvs_reg} : rem_sh;
        quo_next = {quo_reg[QW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(QW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dvd_mag[QW-1:0];
            rem_reg <= '0;
            dvs_reg <= divisor[31] ? 32'(-divisor) : 32'(divisor);
            neg_reg <= dividend[63] ^ divisor[31];
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
            if (cnt_reg == 6'(QW - 1))
            begin
                q_reg <= neg_reg ? -$signed({1'b0, quo_next}) : $signed({1'b0, quo_next});
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

endmodule

// ----- sv/rouu_datapath.sv -----
module rouu_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  rouu_pkg::cmd_t                  cmd,
    output rouu_pkg::sts_t                  sts,
    input  logic [rouu_pkg::THR_W-1:0]      thr,
    input  logic signed [rouu_pkg::DATA_W-1:0] data_value,
    output logic signed [rouu_pkg::DATA_W-1:0] read_value,
    output logic signed [rouu_pkg::DATA_W-1:0] ratio_value,
    output logic [rouu_pkg::CNT_W-1:0]      zeroed_count,
    output logic [1:0]                      status,
    output logic                            out_valid,
    input  logic                            out_stall
);
    import rouu_pkg::*;

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] ratio_reg;
    logic                     ratio_valid_reg;
    logic [IDX_W-1:0]         moved_reg;
    logic signed [63:0]       prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [DATA_W-1:0] rd_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [MAX_DIM-1:0]       w_valid_reg;
    logic                     w_valid_q;

    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] out_read_reg;
    logic signed [DATA_W-1:0] out_ratio_reg;
    logic [CNT_W-1:0]         out_count_reg;
    logic [1:0]               out_status_reg;

    logic signed [DATA_W-1:0] inv_rdata;
    logic signed [DATA_W-1:0] u_rdata;
    logic signed [DATA_W-1:0] w_rdata;
    logic signed [DATA_W-1:0] orow_rdata;
    logic signed [DATA_W-1:0] inv_wdata;
    logic                     inv_we;
    logic [ADDR_W-1:0]        inv_addr;

    logic signed [DATA_W-1:0] mul_a;
    logic signed [DATA_W-1:0] mul_b;
    logic signed [63:0]       rnd_full;
    logic signed [DATA_W-1:0] w_sat;
    logic signed [DATA_W-1:0] upd_val;
    logic                     small_rd;
    logic                     div_done;
    logic signed [63:0]       div_q;

    assign inv_addr = {cmd.inv_row, cmd.inv_col};

    // Memories
    rouu_ram #(.WIDTH(DATA_W), .DEPTH(MAX_DIM * MAX_DIM)) u_inv_ram (
        .clk   (clk),
        .we    (inv_we),
        .waddr (inv_addr),
        .wdata (inv_wdata),
        .raddr (inv_addr),
        .rdata (inv_rdata)
    );

    rouu_ram #(.WIDTH(DATA_W), .DEPTH(MAX_DIM)) u_u_ram (
        .clk   (clk),
        .we    (cmd.u_we),
        .waddr (cmd.vec_col),
        .wdata (data_reg),
        .raddr (cmd.vec_col),
        .rdata (u_rdata)
    );

    rouu_ram #(.WIDTH(DATA_W), .DEPTH(MAX_DIM)) u_w_ram (
        .clk   (clk),
        .we    (cmd.w_we),
        .waddr (cmd.vec_row),
        .wdata (w_sat),
        .raddr (cmd.vec_row),
        .rdata (w_rdata)
    );

    rouu_ram #(.WIDTH(DATA_W), .DEPTH(MAX_DIM)) u_orow_ram (
        .clk   (clk),
        .we    (cmd.orow_we),
        .waddr (cmd.vec_col),
        .wdata (inv_rdata),
        .raddr (cmd.vec_col),
        .rdata (orow_rdata)
    );

    // Divider for the correction term
    rouu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_go),
        .dividend (prod_reg),
        .divisor  (ratio_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Arithmetic around the multiplier and the accumulator
    always_comb
    begin
        if (cmd.mul_sel == MSEL_RATIO)
        begin
            mul_a = inv_rdata;
            mul_b = u_rdata;
        end
        else
        begin
            mul_a = w_valid_q ? w_rdata : '0;
            mul_b = orow_rdata;
        end
        rnd_full = (prod_reg + 64'sd32768) >>> 16;
        w_sat    = sat32(65'(acc_reg));
        upd_val  = sat32(65'(inv_rdata) - 65'(div_q));
        if (is_small(upd_val, thr))
        begin
            upd_val = '0;
        end
        small_rd = is_small(inv_rdata, thr);
    end

    // Matrix write path
    always_comb
    begin
        inv_we = cmd.inv_we | (cmd.spar_chk & small_rd);
        case (cmd.inv_wsel)
            WSEL_DATA:   inv_wdata = data_reg;
            WSEL_UPDATE: inv_wdata = upd_val;
            default:     inv_wdata = '0;
        endcase
        if (cmd.spar_chk)
        begin
            inv_wdata = '0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            data_reg <= data_value;
        end
        if (cmd.mul_go)
        begin
            prod_reg <= mul_a * mul_b;
        end
        w_valid_q <= w_valid_reg[cmd.vec_row];
    end

    // Ratio state, accumulator, counters and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg       <= '0;
            ratio_valid_reg <= 1'b0;
            moved_reg       <= '0;
            acc_reg         <= '0;
            rd_reg          <= '0;
            count_reg       <= '0;
            w_valid_reg     <= '0;
            out_valid_reg   <= 1'b0;
            out_read_reg    <= '0;
            out_ratio_reg   <= '0;
            out_count_reg   <= '0;
            out_status_reg  <= '0;
        end
        else
        begin
            if (cmd.load || cmd.acc_clr)
            begin
                acc_reg <= '0;
            end
            else if (cmd.acc_add)
            begin
                acc_reg <= acc_reg + ACC_W'(rnd_full);
            end
            if (cmd.w_we)
            begin
                w_valid_reg[cmd.vec_row] <= 1'b1;
            end
            if (cmd.ratio_ok)
            begin
                ratio_reg       <= sat32(65'(w_sat) + 65'sd65536);
                ratio_valid_reg <= 1'b1;
                moved_reg       <= cmd.vec_row;
            end
            else if (cmd.ratio_bad)
            begin
                ratio_reg       <= 32'sd65536;
                ratio_valid_reg <= 1'b0;
            end
            else if (cmd.valid_clr)
            begin
                ratio_valid_reg <= 1'b0;
            end
            if (cmd.load)
            begin
                rd_reg    <= '0;
                count_reg <= '0;
            end
            else
            begin
                if (cmd.rd_cap)
                begin
                    rd_reg <= inv_rdata;
                end
                if (cmd.spar_chk && small_rd && count_reg != CNT_MAX)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg  <= 1'b1;
                out_read_reg   <= rd_reg;
                out_ratio_reg  <= ratio_reg;
                out_count_reg  <= count_reg;
                out_status_reg <= cmd.out_status;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.moved_row   = moved_reg;
    assign sts.ratio_valid = ratio_valid_reg;
    assign sts.ratio_zero  = ratio_reg == '0;
    assign sts.div_done    = div_done;
    assign sts.out_free    = !out_valid_reg || !out_stall;

    assign read_value   = out_read_reg;
    assign ratio_value  = out_ratio_reg;
    assign zeroed_count = out_count_reg;
    assign status       = out_status_reg;
    assign out_valid    = out_valid_reg;

    a_valid_clr: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid_clr && !cmd.ratio_ok) |=> !ratio_valid_reg)
        else $error("ratio still valid after a completed update");

endmodule

// ----- sv/rouu_ctrl.sv -----
module rouu_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [2:0]                   operation,
    input  logic [rouu_pkg::IDX_W-1:0]   row_index,
    input  logic [rouu_pkg::IDX_W-1:0]   col_index,
    input  logic [rouu_pkg::DIM_W-1:0]   n_dim,
    output rouu_pkg::cmd_t               cmd,
    input  rouu_pkg::sts_t               sts
);
    import rouu_pkg::*;

    state_t           state_reg, state_next;
    op_t              op_reg;
    logic [IDX_W-1:0] row_reg, col_reg;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    stat_t            stat_reg, stat_next;
    logic [IDX_W-1:0] last;
    logic             row_in, col_in, moved_in, accept;
    logic             j_last, i_last;

    assign last     = IDX_W'(n_dim - DIM_W'(1));
    assign row_in   = {1'b0, row_reg} < n_dim;
    assign col_in   = {1'b0, col_reg} < n_dim;
    assign moved_in = {1'b0, sts.moved_row} < n_dim;
    assign j_last   = j_reg == last;
    assign i_last   = i_reg == last;
    assign in_stall = state_reg != S_IDLE;
    assign accept   = in_valid && !in_stall;

    // State and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            stat_reg  <= STAT_OK;
            op_reg    <= OP_WRITE;
            row_reg   <= '0;
            col_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            stat_reg  <= stat_next;
            if (accept)
            begin
                op_reg  <= op_t'(operation);
                row_reg <= row_index;
                col_reg <= col_index;
            end
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        stat_next    = stat_reg;
        cmd          = '0;
        cmd.inv_row  = i_reg;
        cmd.inv_col  = j_reg;
        cmd.vec_row  = i_reg;
        cmd.vec_col  = j_reg;
        cmd.inv_wsel = WSEL_DATA;
        cmd.mul_sel  = MSEL_RATIO;
        cmd.out_status = stat_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.inv_row = row_reg;
                cmd.inv_col = col_reg;
                cmd.vec_col = row_reg;
                i_next      = '0;
                j_next      = '0;
                stat_next   = STAT_OK;
                state_next  = S_DONE;
                case (op_reg)
                    OP_WRITE:
                    begin
                        cmd.inv_we = row_in && col_in;
                    end
                    OP_WRITE_U:
                    begin
                        cmd.u_we = row_in;
                    end
                    OP_RATIO:
                    begin
                        state_next = S_R_ADDR;
                    end
                    OP_UPDATE:
                    begin
                        if (!sts.ratio_valid || !moved_in)
                            stat_next = STAT_NO_RATIO;
                        else if (sts.ratio_zero)
                            stat_next = STAT_ZERO;
                        else
                            state_next = S_C_ADDR;
                    end
                    OP_READ:
                    begin
                        if (row_in && col_in)
                            state_next = S_RD_CAP;
                    end
                    OP_SPARSIFY:
                    begin
                        state_next = S_S_ADDR;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_RD_CAP:
            begin
                cmd.inv_row = row_reg;
                cmd.inv_col = col_reg;
                cmd.rd_cap  = 1'b1;
                state_next  = S_DONE;
            end
            // Product vector: one multiply-accumulate per entry
            S_R_ADDR:
            begin
                state_next = S_R_MUL;
            end
            S_R_MUL:
            begin
                cmd.mul_go = 1'b1;
                state_next = S_R_ACC;
            end
            S_R_ACC:
            begin
                cmd.acc_add = 1'b1;
                if (j_last)
                begin
                    state_next = S_R_WR;
                end
                else
                begin
                    j_next     = j_reg + IDX_W'(1);
                    state_next = S_R_ADDR;
                end
            end
            S_R_WR:
            begin
                cmd.w_we     = 1'b1;
                cmd.ratio_ok = i_reg == row_reg;
                cmd.acc_clr  = 1'b1;
                j_next       = '0;
                if (i_last)
                begin
                    state_next = S_R_END;
                end
                else
                begin
                    i_next     = i_reg + IDX_W'(1);
                    state_next = S_R_ADDR;
                end
            end
            S_R_END:
            begin
                if (!row_in)
                begin
                    cmd.ratio_bad = 1'b1;
                    stat_next     = STAT_NO_RATIO;
                end
                state_next = S_DONE;
            end
            // Copy of the old moved row
            S_C_ADDR:
            begin
                cmd.inv_row = sts.moved_row;
                state_next  = S_C_WR;
            end
            S_C_WR:
            begin
                cmd.inv_row = sts.moved_row;
                cmd.orow_we = 1'b1;
                if (j_last)
                begin
                    j_next     = '0;
                    i_next     = '0;
                    state_next = S_U_ADDR;
                end
                else
                begin
                    j_next     = j_reg + IDX_W'(1);
                    state_next = S_C_ADDR;
                end
            end
            // Rank-one correction, one entry at a time
            S_U_ADDR:
            begin
                state_next = S_U_MUL;
            end
            S_U_MUL:
            begin
                cmd.mul_sel = MSEL_UPDATE;
                cmd.mul_go  = 1'b1;
                state_next  = S_U_DIV;
            end
            S_U_DIV:
            begin
                cmd.div_go = 1'b1;
                state_next = S_U_WAIT;
            end
            S_U_WAIT:
            begin
                if (sts.div_done)
                    state_next = S_U_WR;
            end
            S_U_WR:
            begin
                cmd.inv_we   = 1'b1;
                cmd.inv_wsel = WSEL_UPDATE;
                state_next   = S_U_ADDR;
                if (j_last)
                begin
                    j_next = '0;
                    if (i_last)
                    begin
                        cmd.valid_clr = 1'b1;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        i_next = i_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    j_next = j_reg + IDX_W'(1);
                end
            end
            // Sparsify sweep
            S_S_ADDR:
            begin
                state_next = S_S_CHK;
            end
            S_S_CHK:
            begin
                cmd.spar_chk = 1'b1;
                state_next   = S_S_ADDR;
                if (j_last)
                begin
                    j_next = '0;
                    if (i_last)
                        state_next = S_DONE;
                    else
                        i_next = i_reg + IDX_W'(1);
                end
                else
                begin
                    j_next = j_reg + IDX_W'(1);
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_DECODE)
        else $error("accepted beat not decoded");

    a_upd_wr: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_U_WR |-> $past(state_reg) == S_U_WAIT)
        else $error("update written before the quotient");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded over a waiting beat");

endmodule

// ----- sv/rank_one_inverse_update_core.sv -----
// Rank-one inverse update core.
// Input channel: in_valid/in_stall with operation, row_index, col_index and
// data_value; a beat is taken when in_valid is high and in_stall low.
// Output channel: out_valid/out_stall; every input beat gives exactly one
// result beat (read_value, ratio_value, zeroed_count, status).
// Configuration: cfg_valid/cfg_ready (always ready) with cfg_index 0 for the
// matrix size and 1 for the drop threshold; write only while the core is idle.
// One item is handled at a time. Writes go from decode straight to the result
// state; reads add a capture state. The ratio operation's run time is set by the
// single multiply-accumulate path; the update's run time is set by the
// bit-serial divider that forms each correction term.
// Sparsify reads each matrix entry once and writes zero over the small ones.
// A finished result waits in the output register while the receiver stalls;
// the next item is taken meanwhile and held at its end until the register frees.
// Reset (rst_n, asynchronous) clears the ratio state and the output register;
// no clearing pass is needed, the matrix and u are undefined until written.
module rank_one_inverse_update_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [2:0]           operation,
    input  logic [5:0]           row_index,
    input  logic [5:0]           col_index,
    input  logic signed [31:0]   data_value,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [31:0]   read_value,
    output logic signed [31:0]   ratio_value,
    output logic [12:0]          zeroed_count,
    output logic [1:0]           status
);
    import rouu_pkg::*;

    logic [DIM_W-1:0] msize_reg;
    logic [THR_W-1:0] thr_reg;
    logic [DIM_W-1:0] n_dim;
    cmd_t             cmd;
    sts_t             sts;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msize_reg <= DIM_W'(MAX_DIM);
            thr_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MATRIX_SIZE: msize_reg <= cfg_data[DIM_W-1:0];
                CFG_DROP_THR:    thr_reg   <= cfg_data[THR_W-1:0];
                default:         thr_reg   <= thr_reg;
            endcase
        end
    end

    // Matrix size in use, clamped to one through the maximum
    always_comb
    begin
        if (msize_reg == '0)
            n_dim = DIM_W'(1);
        else if (msize_reg > DIM_W'(MAX_DIM))
            n_dim = DIM_W'(MAX_DIM);
        else
            n_dim = msize_reg;
    end

    rouu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .row_index (row_index),
        .col_index (col_index),
        .n_dim     (n_dim),
        .cmd       (cmd),
        .sts       (sts)
    );

    rouu_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .thr          (thr_reg),
        .data_value   (data_value),
        .read_value   (read_value),
        .ratio_value  (ratio_value),
        .zeroed_count (zeroed_count),
        .status       (status),
        .out_valid    (out_valid),
        .out_stall    (out_stall)
    );

endmodule
